@@ sv/mbbec_pkg.sv @@
`default_nettype none

package mbbec_pkg;

    // Fixed field widths
    localparam int ACT_W     = 3;
    localparam int KIND_W    = 2;
    localparam int ADDR_W    = 15;
    localparam int BIT_IDX_W = 4;
    localparam int CNT_W     = 16;
    localparam int SEED_W    = 32;
    localparam int DWELL_W   = 5;
    localparam int WCOUNT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 32;

    // Default geometry
    localparam int DATA_BITS_DEF = 16;
    localparam int MAX_WORDS_DEF = 32768;
    localparam int MAX_DWELL_DEF = 16;

    // Generator constants
    localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1664525;
    localparam logic [SEED_W-1:0] LCG_INC    = 32'd1013904223;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'h1357_9BDF;
    // State one step past the reset seed
    localparam logic [SEED_W-1:0] LCG_RESET  =
        SEED_W'(64'(SEED_RESET) * 64'(LCG_MUL) + 64'(LCG_INC));

    localparam logic [DWELL_W-1:0]  DWELL_RESET  = 5'd1;
    localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 16'd32768;
    localparam logic [CNT_W-1:0]    CNT_MAX      = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_START_WR = 3'd0,
        ACT_WRITE    = 3'd1,
        ACT_START_RD = 3'd2,
        ACT_CHECK    = 3'd3,
        ACT_QUERY    = 3'd4
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK   = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED   = 2'd0,
        CFG_DWELL  = 2'd1,
        CFG_WCOUNT = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ sv/memory_bus_bit_error_census_core.sv @@
// Memory data-bus test engine. A 32-bit linear congruential generator, started
// from the seed register by a start-write or start-read item, supplies the
// upper DATA_BITS of its state as the pattern. Write-next answers with dwell
// identical write requests (dwell clamped to 1..MAX_DWELL, last on the final
// one); check-word compares the regenerated pattern with the read data and
// updates five saturating counters per data line; query returns one line's
// counters, the error mask and the lowest-index line with the most errors.
// Each result is registered, so items flow at one per clock while m_ready is
// high; the only holdoff is the output register, which keeps a write request
// through its repeats. The generator multiplier works one step ahead from a
// register, and the worst line is tracked as counts change, so a query right
// after a check already sees the check's effect. The user must write
// configuration only while no item is in flight; the block does not enforce it.
`default_nettype none

module memory_bus_bit_error_census_core #(
    parameter int DATA_BITS = mbbec_pkg::DATA_BITS_DEF,
    parameter int MAX_WORDS = mbbec_pkg::MAX_WORDS_DEF,
    parameter int MAX_DWELL = mbbec_pkg::MAX_DWELL_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [mbbec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mbbec_pkg::CFG_DW-1:0]      cfg_wr_data,
    // input items
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [mbbec_pkg::ACT_W-1:0]       s_action,
    input  wire logic [DATA_BITS-1:0]              s_read_data,
    input  wire logic [mbbec_pkg::BIT_IDX_W-1:0]   s_bit_index,
    // result items
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [mbbec_pkg::KIND_W-1:0]           m_kind,
    output logic [mbbec_pkg::ADDR_W-1:0]           m_address,
    output logic [DATA_BITS-1:0]                   m_write_data,
    output logic [DATA_BITS-1:0]                   m_mismatch,
    output logic                                   m_last,
    output logic [mbbec_pkg::CNT_W-1:0]            m_err_count,
    output logic [mbbec_pkg::CNT_W-1:0]            m_zero_written,
    output logic [mbbec_pkg::CNT_W-1:0]            m_zero_ok,
    output logic [mbbec_pkg::CNT_W-1:0]            m_one_written,
    output logic [mbbec_pkg::CNT_W-1:0]            m_one_ok,
    output logic [DATA_BITS-1:0]                   m_error_mask,
    output logic [$clog2(DATA_BITS)-1:0]           m_worst_bit
);

    import mbbec_pkg::*;

    localparam int WORST_W = $clog2(DATA_BITS);
    localparam int IDX_W   = $clog2(MAX_WORDS + 1);
    localparam int CMP_W   = (IDX_W > WCOUNT_W) ? IDX_W : WCOUNT_W;
    localparam int RPT_W   = (MAX_DWELL > 1) ? $clog2(MAX_DWELL) : 1;

    // lowest set position of a line vector
    function automatic logic [WORST_W-1:0] lowest_set(input logic [DATA_BITS-1:0] v);
        logic [WORST_W-1:0] r;
        r = '0;
        for (int i = DATA_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = WORST_W'(i);
            end
        end
        return r;
    endfunction

    // configuration registers
    logic [SEED_W-1:0]   seed_reg;
    logic [DWELL_W-1:0]  dwell_reg;
    logic [WCOUNT_W-1:0] wcount_reg;

    // engine state
    logic [SEED_W-1:0]   gen_reg, gen_next;     // state the next word step lands on
    logic [IDX_W-1:0]    widx_reg, widx_next;
    logic [CNT_W-1:0]    err_cnt_reg [DATA_BITS];
    logic [CNT_W-1:0]    err_cnt_next [DATA_BITS];
    logic [CNT_W-1:0]    z_cnt_reg [DATA_BITS];
    logic [CNT_W-1:0]    z_cnt_next [DATA_BITS];
    logic [CNT_W-1:0]    zok_cnt_reg [DATA_BITS];
    logic [CNT_W-1:0]    zok_cnt_next [DATA_BITS];
    logic [CNT_W-1:0]    o_cnt_reg [DATA_BITS];
    logic [CNT_W-1:0]    o_cnt_next [DATA_BITS];
    logic [CNT_W-1:0]    ook_cnt_reg [DATA_BITS];
    logic [CNT_W-1:0]    ook_cnt_next [DATA_BITS];
    logic [CNT_W-1:0]    max_err_reg, max_err_next;
    logic [WORST_W-1:0]  worst_reg, worst_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [RPT_W-1:0]    rem_reg, rem_next;
    kind_t               kind_reg, kind_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [DATA_BITS-1:0] wdata_reg, wdata_next;
    logic [DATA_BITS-1:0] mism_reg, mism_next;
    logic [CNT_W-1:0]    q_err_reg, q_err_next;
    logic [CNT_W-1:0]    q_z_reg, q_z_next;
    logic [CNT_W-1:0]    q_zok_reg, q_zok_next;
    logic [CNT_W-1:0]    q_o_reg, q_o_next;
    logic [CNT_W-1:0]    q_ook_reg, q_ook_next;
    logic [DATA_BITS-1:0] q_mask_reg, q_mask_next;
    logic [WORST_W-1:0]  q_worst_reg, q_worst_next;

    logic                in_accept;
    action_t             act;
    logic                start;
    logic [SEED_W-1:0]   lcg_src;
    logic [SEED_W-1:0]   lcg_prod;
    logic [SEED_W-1:0]   lcg_step;
    logic [DATA_BITS-1:0] pattern;
    logic [DATA_BITS-1:0] bad;
    logic                in_range;
    logic [RPT_W-1:0]    rem_init;
    logic [DATA_BITS-1:0] inc_err;
    logic [DATA_BITS-1:0] at_max;
    logic [DATA_BITS-1:0] at_max_m1;
    logic [DATA_BITS-1:0] err_mask;
    logic                grow;
    logic [WORST_W-1:0]  chk_worst;
    logic [CNT_W-1:0]    chk_max;
    logic [WORST_W-1:0]  q_idx;
    logic                q_in_range;

    // handshake: take an item whenever the output register is free next edge
    assign s_ready   = !out_valid_reg || (m_ready && (rem_reg == '0));
    assign in_accept = s_valid && s_ready;
    assign act       = action_t'(s_action);
    assign start     = (act == ACT_START_WR) || (act == ACT_START_RD);

    // generator step, one ahead of use
    assign lcg_src  = start ? seed_reg : gen_reg;
    assign lcg_prod = lcg_src * LCG_MUL;
    assign lcg_step = lcg_prod + LCG_INC;
    assign pattern  = gen_reg[SEED_W-1 -: DATA_BITS];
    assign bad      = pattern ^ s_read_data;

    assign in_range = (CMP_W'(widx_reg) < CMP_W'(wcount_reg))
                   && (CMP_W'(widx_reg) < CMP_W'(MAX_WORDS));

    // repeats after the first write request
    always_comb begin
        if (dwell_reg == '0) begin
            rem_init = '0;
        end else if (int'(dwell_reg) > MAX_DWELL) begin
            rem_init = RPT_W'(MAX_DWELL - 1);
        end else begin
            rem_init = RPT_W'(dwell_reg - 1'b1);
        end
    end

    // worst-line tracking for a check
    always_comb begin
        for (int b = 0; b < DATA_BITS; b++) begin
            inc_err[b]   = bad[b] && (err_cnt_reg[b] != CNT_MAX);
            at_max[b]    = (err_cnt_reg[b] == max_err_reg);
            at_max_m1[b] = (err_cnt_reg[b] == (max_err_reg - 1'b1));
            err_mask[b]  = (err_cnt_reg[b] != '0);
        end
        grow = |(at_max & inc_err);
        if (grow) begin
            chk_max   = max_err_reg + 1'b1;
            chk_worst = lowest_set(at_max & inc_err);
        end else begin
            chk_max   = max_err_reg;
            chk_worst = lowest_set(at_max | (at_max_m1 & inc_err));
        end
    end

    // query line select
    assign q_in_range = (int'(s_bit_index) < DATA_BITS);
    assign q_idx      = WORST_W'(s_bit_index);

    // next state
    always_comb begin
        gen_next       = gen_reg;
        widx_next      = widx_reg;
        err_cnt_next   = err_cnt_reg;
        z_cnt_next     = z_cnt_reg;
        zok_cnt_next   = zok_cnt_reg;
        o_cnt_next     = o_cnt_reg;
        ook_cnt_next   = ook_cnt_reg;
        max_err_next   = max_err_reg;
        worst_next     = worst_reg;
        out_valid_next = out_valid_reg;
        rem_next       = rem_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        wdata_next     = wdata_reg;
        mism_next      = mism_reg;
        q_err_next     = q_err_reg;
        q_z_next       = q_z_reg;
        q_zok_next     = q_zok_reg;
        q_o_next       = q_o_reg;
        q_ook_next     = q_ook_reg;
        q_mask_next    = q_mask_reg;
        q_worst_next   = q_worst_reg;

        // drain: repeat or retire the held item
        if (out_valid_reg && m_ready) begin
            if (rem_reg != '0) begin
                rem_next = rem_reg - 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end

        if (in_accept) begin
            out_valid_next = 1'b1;
            rem_next       = '0;
            kind_next      = KIND_ACK;
            addr_next      = '0;
            wdata_next     = '0;
            mism_next      = '0;
            q_err_next     = '0;
            q_z_next       = '0;
            q_zok_next     = '0;
            q_o_next       = '0;
            q_ook_next     = '0;
            q_mask_next    = '0;
            q_worst_next   = '0;

            case (act)
                ACT_START_WR, ACT_START_RD: begin
                    gen_next  = lcg_step;
                    widx_next = '0;
                    if (act == ACT_START_WR) begin
                        for (int b = 0; b < DATA_BITS; b++) begin
                            err_cnt_next[b] = '0;
                            z_cnt_next[b]   = '0;
                            zok_cnt_next[b] = '0;
                            o_cnt_next[b]   = '0;
                            ook_cnt_next[b] = '0;
                        end
                        max_err_next = '0;
                        worst_next   = '0;
                    end
                end
                ACT_WRITE: begin
                    if (in_range) begin
                        kind_next  = KIND_WRITE;
                        addr_next  = ADDR_W'(widx_reg);
                        wdata_next = pattern;
                        rem_next   = rem_init;
                        widx_next  = widx_reg + 1'b1;
                        gen_next   = lcg_step;
                    end
                end
                ACT_CHECK: begin
                    if (in_range) begin
                        kind_next  = KIND_CHECK;
                        addr_next  = ADDR_W'(widx_reg);
                        wdata_next = pattern;
                        mism_next  = bad;
                        widx_next  = widx_reg + 1'b1;
                        gen_next   = lcg_step;
                        // per-line saturating counters
                        for (int b = 0; b < DATA_BITS; b++) begin
                            if (pattern[b]) begin
                                if (o_cnt_reg[b] != CNT_MAX) begin
                                    o_cnt_next[b] = o_cnt_reg[b] + 1'b1;
                                end
                                if (!bad[b] && (ook_cnt_reg[b] != CNT_MAX)) begin
                                    ook_cnt_next[b] = ook_cnt_reg[b] + 1'b1;
                                end
                            end else begin
                                if (z_cnt_reg[b] != CNT_MAX) begin
                                    z_cnt_next[b] = z_cnt_reg[b] + 1'b1;
                                end
                                if (!bad[b] && (zok_cnt_reg[b] != CNT_MAX)) begin
                                    zok_cnt_next[b] = zok_cnt_reg[b] + 1'b1;
                                end
                            end
                            if (inc_err[b]) begin
                                err_cnt_next[b] = err_cnt_reg[b] + 1'b1;
                            end
                        end
                        max_err_next = chk_max;
                        worst_next   = chk_worst;
                    end
                end
                ACT_QUERY: begin
                    kind_next    = KIND_QUERY;
                    q_mask_next  = err_mask;
                    q_worst_next = worst_reg;
                    if (q_in_range) begin
                        q_err_next = err_cnt_reg[q_idx];
                        q_z_next   = z_cnt_reg[q_idx];
                        q_zok_next = zok_cnt_reg[q_idx];
                        q_o_next   = o_cnt_reg[q_idx];
                        q_ook_next = ook_cnt_reg[q_idx];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= SEED_RESET;
            dwell_reg  <= DWELL_RESET;
            wcount_reg <= WCOUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_SEED:   seed_reg   <= cfg_wr_data[SEED_W-1:0];
                CFG_DWELL:  dwell_reg  <= cfg_wr_data[DWELL_W-1:0];
                CFG_WCOUNT: wcount_reg <= cfg_wr_data[WCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // engine state and output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg       <= LCG_RESET;
            widx_reg      <= '0;
            max_err_reg   <= '0;
            worst_reg     <= '0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            for (int b = 0; b < DATA_BITS; b++) begin
                err_cnt_reg[b] <= '0;
                z_cnt_reg[b]   <= '0;
                zok_cnt_reg[b] <= '0;
                o_cnt_reg[b]   <= '0;
                ook_cnt_reg[b] <= '0;
            end
        end else begin
            gen_reg       <= gen_next;
            widx_reg      <= widx_next;
            max_err_reg   <= max_err_next;
            worst_reg     <= worst_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            err_cnt_reg   <= err_cnt_next;
            z_cnt_reg     <= z_cnt_next;
            zok_cnt_reg   <= zok_cnt_next;
            o_cnt_reg     <= o_cnt_next;
            ook_cnt_reg   <= ook_cnt_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        addr_reg    <= addr_next;
        wdata_reg   <= wdata_next;
        mism_reg    <= mism_next;
        q_err_reg   <= q_err_next;
        q_z_reg     <= q_z_next;
        q_zok_reg   <= q_zok_next;
        q_o_reg     <= q_o_next;
        q_ook_reg   <= q_ook_next;
        q_mask_reg  <= q_mask_next;
        q_worst_reg <= q_worst_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = kind_reg;
    assign m_address      = addr_reg;
    assign m_write_data   = wdata_reg;
    assign m_mismatch     = mism_reg;
    assign m_last         = (rem_reg == '0);
    assign m_err_count    = q_err_reg;
    assign m_zero_written = q_z_reg;
    assign m_zero_ok      = q_zok_reg;
    assign m_one_written  = q_o_reg;
    assign m_one_ok       = q_ook_reg;
    assign m_error_mask   = q_mask_reg;
    assign m_worst_bit    = q_worst_reg;

endmodule

`default_nettype wire
